>>> rtl/core/bbmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte budget message queue package
// Shared constants, payload structs, result kinds and ring helpers.
// ----------------------------------------------------------------------------
package bbmq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] BUDGET_RESET = 16'd4096;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
    localparam logic [2:0] KIND_TOO_BIG   = 3'd1;
    localparam logic [2:0] KIND_EVICTED   = 3'd2;
    localparam logic [2:0] KIND_DELIVERED = 3'd3;
    localparam logic [2:0] KIND_EMPTY     = 3'd4;
    localparam logic [2:0] KIND_WAITING   = 3'd5;
    localparam logic [2:0] KIND_REFUSED   = 3'd6;

    typedef struct packed {
        logic        operation;
        logic [15:0] sender;
        logic [15:0] msg_size;
        logic        receipt;
        logic [15:0] payload_handle;
        logic        nonblocking;
    } req_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] out_sender;
        logic [15:0] out_size;
        logic        out_receipt;
        logic [15:0] out_handle;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [15:0] sender;
        logic [15:0] msg_size;
        logic        receipt;
        logic [15:0] handle;
    } desc_t;

    typedef struct packed {
        logic  push;
        logic  pop;
        desc_t wdata;
    } ring_ctl_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      total;
        desc_t            head;
    } ring_sts_t;

    function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] i);
        if (i == IDX_W'(QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return i + 1'b1;
    endfunction

endpackage

>>> rtl/core/bbmq_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor ring
// Circular store of message descriptors with head, tail, count and byte total.
// ----------------------------------------------------------------------------
module bbmq_ring (
    input  logic                clk,
    input  logic                rst_n,
    input  bbmq_pkg::ring_ctl_t ctl,
    output bbmq_pkg::ring_sts_t sts
);

    bbmq_pkg::desc_t                 mem [bbmq_pkg::QUEUE_DEPTH];
    bbmq_pkg::desc_t                 rd_reg;
    logic [bbmq_pkg::IDX_W-1:0]      head_reg, head_next;
    logic [bbmq_pkg::IDX_W-1:0]      tail_reg, tail_next;
    logic [bbmq_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [15:0]                     total_reg, total_next;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        if (ctl.pop)
        begin
            head_next  = bbmq_pkg::bump(head_reg);
            count_next = count_reg - 1'b1;
            total_next = total_reg - rd_reg.msg_size;
            if (count_reg == bbmq_pkg::CNT_W'(1))
            begin
                head_next  = '0;
                tail_next  = '0;
                total_next = '0;
            end
        end
        else if (ctl.push)
        begin
            tail_next  = bbmq_pkg::bump(tail_reg);
            count_next = count_reg + 1'b1;
            total_next = total_reg + ctl.wdata.msg_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    // read follows the next head so the registered data matches the head once it updates
    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[tail_reg] <= ctl.wdata;
        end
        rd_reg <= mem[head_next];
    end

    assign sts.count = count_reg;
    assign sts.total = total_reg;
    assign sts.head  = rd_reg;

endmodule

>>> rtl/core/byte_budget_message_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte budget message queue
// Drop-oldest descriptor FIFO bounded by a byte budget and a slot count.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries push and pop requests.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one or more results per
//   request; the final one of a request has last set.
//   cfg channel (cfg_valid / cfg_ready / cfg_data) writes the byte budget;
//   cfg_ready is high while the block is idle.
//   A request is captured in the idle state and decided in the exec state once
//   the output register can take a result. A push returns to the exec state
//   for each evicted descriptor and passes through the deliver state when it
//   serves a waiting pop. req_stall stays high until the last result
//   of the request sits in the output register.
//   When the receiver stalls, the output register holds and the sequencer
//   waits; it never drops a result.
//   Reset empties the queue, clears the waiter and sets the budget to 4096.
// ----------------------------------------------------------------------------
module byte_budget_message_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bbmq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bbmq_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [15:0]    cfg_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_DELIV = 2'd2;

    logic [1:0]          state_reg, state_next;
    bbmq_pkg::req_t      item_reg;
    logic                waiter_reg, waiter_next;
    logic [15:0]         budget_reg;
    bbmq_pkg::rsp_t      rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;
    bbmq_pkg::ring_ctl_t ring_ctl;
    bbmq_pkg::ring_sts_t ring_sts;
    logic                can_emit;
    logic                too_big;
    logic                must_evict;
    logic [16:0]         sum;

    bbmq_ring u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .sts   (ring_sts)
    );

    assign can_emit = !rsp_valid_reg || !rsp_stall;
    assign sum      = {1'b0, ring_sts.total} + {1'b0, item_reg.msg_size};
    assign too_big  = item_reg.msg_size >= budget_reg;
    assign must_evict = (ring_sts.count != '0) &&
                        ((sum > {1'b0, budget_reg}) ||
                         (ring_sts.count == bbmq_pkg::CNT_W'(bbmq_pkg::QUEUE_DEPTH)));

    always_comb
    begin
        state_next     = state_reg;
        waiter_next    = waiter_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ring_ctl.push  = 1'b0;
        ring_ctl.pop   = 1'b0;
        ring_ctl.wdata.sender   = item_reg.sender;
        ring_ctl.wdata.msg_size = item_reg.msg_size;
        ring_ctl.wdata.receipt  = item_reg.receipt;
        ring_ctl.wdata.handle   = item_reg.payload_handle;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (can_emit)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.last  = 1'b1;
                    state_next     = S_IDLE;
                    if (item_reg.operation == bbmq_pkg::OP_POP)
                    begin
                        if (waiter_reg)
                        begin
                            rsp_next.kind = bbmq_pkg::KIND_REFUSED;
                        end
                        else if (ring_sts.count == '0)
                        begin
                            if (item_reg.nonblocking)
                            begin
                                rsp_next.kind = bbmq_pkg::KIND_EMPTY;
                            end
                            else
                            begin
                                rsp_next.kind = bbmq_pkg::KIND_WAITING;
                                waiter_next   = 1'b1;
                            end
                        end
                        else
                        begin
                            rsp_next.kind        = bbmq_pkg::KIND_DELIVERED;
                            rsp_next.out_sender  = ring_sts.head.sender;
                            rsp_next.out_size    = ring_sts.head.msg_size;
                            rsp_next.out_receipt = ring_sts.head.receipt;
                            rsp_next.out_handle  = ring_sts.head.handle;
                            ring_ctl.pop         = 1'b1;
                        end
                    end
                    else if (too_big)
                    begin
                        rsp_next.kind = bbmq_pkg::KIND_TOO_BIG;
                    end
                    else if (must_evict)
                    begin
                        rsp_next.kind        = bbmq_pkg::KIND_EVICTED;
                        rsp_next.out_sender  = ring_sts.head.sender;
                        rsp_next.out_size    = ring_sts.head.msg_size;
                        rsp_next.out_receipt = ring_sts.head.receipt;
                        rsp_next.out_handle  = ring_sts.head.handle;
                        rsp_next.last        = 1'b0;
                        ring_ctl.pop         = 1'b1;
                        state_next           = S_EXEC;
                    end
                    else if (waiter_reg)
                    begin
                        // queue is empty: hand the new message straight to the waiter
                        rsp_next.kind = bbmq_pkg::KIND_ACCEPTED;
                        rsp_next.last = 1'b0;
                        waiter_next   = 1'b0;
                        state_next    = S_DELIV;
                    end
                    else
                    begin
                        rsp_next.kind = bbmq_pkg::KIND_ACCEPTED;
                        ring_ctl.push = 1'b1;
                    end
                end
            end
            S_DELIV:
            begin
                if (can_emit)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next             = '0;
                    rsp_next.kind        = bbmq_pkg::KIND_DELIVERED;
                    rsp_next.out_sender  = item_reg.sender;
                    rsp_next.out_size    = item_reg.msg_size;
                    rsp_next.out_receipt = item_reg.receipt;
                    rsp_next.out_handle  = item_reg.payload_handle;
                    rsp_next.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            waiter_reg    <= 1'b0;
            budget_reg    <= bbmq_pkg::BUDGET_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            waiter_reg    <= waiter_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (req_valid && !req_stall)
        begin
            item_reg <= req;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_sts.count <= bbmq_pkg::CNT_W'(bbmq_pkg::QUEUE_DEPTH))
        else $error("descriptor count exceeds ring depth");

    a_waiter_empty: assert property (@(posedge clk) disable iff (!rst_n)
        waiter_reg |-> (ring_sts.count == '0))
        else $error("waiter pending while queue holds descriptors");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_sts.count == '0) |-> (ring_sts.total == '0))
        else $error("byte total nonzero on empty queue");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && can_emit && rsp_valid_next && rsp_next.last) |=>
            (state_reg == S_IDLE))
        else $error("sequencer busy after final result");
`endif

endmodule
